// ===== rtl/core/first_fit_region_allocator_core_macros.svh =====
// assertion macros for the first-fit region allocator
// needs clk and rst in the scope of the module that uses them
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FFRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ffra_pkg.sv =====
// shared types and constants of the first-fit region allocator
// no dependencies
package ffra_pkg;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int ENTRY_W          = 33;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] request_bytes;
    logic [15:0] payload_offset;
  } ffra_in_t;

  typedef struct packed {
    logic [15:0] granted_offset;
    logic [1:0]  status;
  } ffra_out_t;

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] size;
    logic        free;
  } ffra_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SPLIT,
    S_HIT_WR,
    S_MERGE
  } ffra_state_t;

endpackage

// ===== rtl/core/first_fit_region_allocator_core.sv =====
// first-fit region allocator: block table in one ram, read-modify-write sequencer
// append is written straight from idle; first-fit scans the table and, for a split,
// shifts the tail up and writes the remainder; free scans, then walks to merge free runs
// throughput: one item at a time, bounded by the table walk through the single ram read port
// reset (synchronous, rst high) clears block count, bump offset, state and result valid; region 65535
// table contents are not cleared: only entries below the block count are ever used
module first_fit_region_allocator_core #(
  parameter int MAX_BLOCKS   = ffra_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffra_pkg::DEF_HEADER_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffra_pkg::ffra_in_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ffra_pkg::ffra_out_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  import ffra_pkg::*;

  `include "first_fit_region_allocator_core_macros.svh"

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);
  localparam logic [15:0]   HDR   = 16'(HEADER_BYTES);

  // control and config registers
  ffra_state_t state, state_next;
  logic [15:0] region;
  logic [CW-1:0] count;
  logic [16:0] bump;

  // latched item
  logic        func_r;
  logic [15:0] req_r;
  logic [15:0] poff_r;

  // walk pointers; rd_ptr issues reads, chk_* tracks the data coming back
  logic [CW-1:0] rd_ptr;
  logic          chk_vld;
  logic [CW-1:0] chk_idx;
  logic [CW-1:0] hit_idx;
  ffra_entry_t   hit_ent;
  logic          split_r;
  logic [CW-1:0] wr_ptr;
  ffra_entry_t   acc;
  logic          acc_vld;

  // result register
  logic      res_valid;
  ffra_out_t res;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  ffra_entry_t       rent;

  logic      fin;
  ffra_out_t fin_res;

  ffra_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rent = ffra_entry_t'(ram_rdata);

  // handshakes: one item in flight, output register parts the two sides
  assign in_stall  = (state != S_IDLE) || (res_valid && out_stall);
  assign out_valid = res_valid;
  assign out_item  = res;
  assign cfg_ready = 1'b1;

  logic accept;
  assign accept = in_valid && !in_stall;

  // bump append check: bump + request + header below region size
  logic [17:0] bump_sum;
  logic        fits;
  logic        tbl_full;
  assign bump_sum = 18'(bump) + 18'(in_item.request_bytes) + 18'(HDR);
  assign fits     = bump_sum < 18'(region);
  assign tbl_full = count >= MAX_C;

  // scan compare
  logic rd_more;
  logic alloc_match, free_match, scan_hit, scan_end;
  assign rd_more     = rd_ptr < count;
  assign alloc_match = rent.free && (rent.size >= req_r);
  assign free_match  = (17'(rent.off) + 17'(HDR)) == 17'(poff_r);
  assign scan_hit    = chk_vld && ((func_r == FUNC_FREE) ? free_match : alloc_match);
  assign scan_end    = !chk_vld && !rd_more;

  // split of the found block
  logic [15:0] rem;
  logic        split_need;
  assign rem        = rent.size - req_r;
  assign split_need = rem >= HDR;

  // shift walk runs the source index down to hit + 1
  logic sh_more, sh_end;
  assign sh_more = rd_ptr >= (hit_idx + CW'(1));
  assign sh_end  = !sh_more && !chk_vld;

  // merge walk: the freed entry reads back as free
  ffra_entry_t ment;
  logic        merge;
  always_comb begin
    ment = rent;
    if (chk_idx == hit_idx) begin
      ment.free = 1'b1;
    end
  end
  assign merge = acc_vld && acc.free && ment.free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !(in_item.func == FUNC_ALLOC && fits)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          if (func_r == FUNC_FREE) begin
            state_next = S_MERGE;
          end else if (split_need && tbl_full) begin
            state_next = S_IDLE;
          end else if (split_need) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_HIT_WR;
          end
        end else if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (sh_end) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT:  state_next = S_HIT_WR;
      S_HIT_WR: state_next = S_IDLE;
      S_MERGE: begin
        if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram writes and result
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = ENTRY_W'({in_item.request_bytes, in_item.request_bytes, 1'b0});
    fin       = 1'b0;
    fin_res   = '0;
    case (state)
      S_IDLE: begin
        if (accept && in_item.func == FUNC_ALLOC && fits) begin
          fin = 1'b1;
          if (tbl_full) begin
            fin_res.status = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = count[AW-1:0];
            ram_wdata = {bump[15:0], in_item.request_bytes, 1'b0};
            fin_res.granted_offset = bump[15:0] + HDR;
            fin_res.status = STAT_OK;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          if (func_r == FUNC_ALLOC && split_need && tbl_full) begin
            fin = 1'b1;
            fin_res.status = STAT_FULL;
          end
        end else if (scan_end) begin
          fin = 1'b1;
          fin_res.status = (func_r == FUNC_FREE) ? STAT_UNKNOWN : STAT_NOSPACE;
        end
      end
      S_SHIFT: begin
        if (chk_vld) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(chk_idx + CW'(1));
          ram_wdata = ram_rdata;
        end
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hit_idx + CW'(1));
        ram_wdata = {hit_ent.off + HDR + req_r, hit_ent.size - req_r - HDR, 1'b1};
      end
      S_HIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx[AW-1:0];
        ram_wdata = {hit_ent.off, req_r, 1'b0};
        fin       = 1'b1;
        fin_res.granted_offset = hit_ent.off + HDR;
        fin_res.status = STAT_OK;
      end
      S_MERGE: begin
        if (chk_vld && !merge && acc_vld) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr[AW-1:0];
          ram_wdata = acc;
        end else if (scan_end) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr[AW-1:0];
          ram_wdata = acc;
          fin       = 1'b1;
          fin_res.status = STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      region    <= 16'hFFFF;
      count     <= '0;
      bump      <= '0;
      res_valid <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        region <= cfg_data;
      end
      if (fin) begin
        res_valid <= 1'b1;
      end else if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      // appends bump the offset and grow the table
      if (state == S_IDLE && fin && ram_we) begin
        count <= count + CW'(1);
        bump  <= bump_sum[16:0];
      end
      if (state == S_HIT_WR && split_r) begin
        count <= count + CW'(1);
      end
      if (state == S_MERGE && scan_end) begin
        count <= wr_ptr + CW'(1);
      end
      case (state)
        S_SCAN, S_MERGE: chk_vld <= (state_next == state) && rd_more;
        S_SHIFT:         chk_vld <= sh_more;
        default:         chk_vld <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (fin) begin
      res <= fin_res;
    end
    chk_idx <= rd_ptr;
    case (state)
      S_IDLE: begin
        func_r  <= in_item.func;
        req_r   <= in_item.request_bytes;
        poff_r  <= in_item.payload_offset;
        rd_ptr  <= '0;
        acc_vld <= 1'b0;
        wr_ptr  <= '0;
      end
      S_SCAN: begin
        if (scan_hit) begin
          hit_idx <= chk_idx;
          hit_ent <= rent;
          split_r <= split_need;
          rd_ptr  <= (func_r == FUNC_FREE) ? '0 : count - CW'(1);
          acc_vld <= 1'b0;
          wr_ptr  <= '0;
        end else if (rd_more) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
      end
      S_SHIFT: begin
        if (sh_more) begin
          rd_ptr <= rd_ptr - CW'(1);
        end
      end
      S_MERGE: begin
        if (rd_more) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        if (chk_vld) begin
          if (merge) begin
            acc.size <= acc.size + ment.size + HDR;
          end else begin
            if (acc_vld) begin
              wr_ptr <= wr_ptr + CW'(1);
            end
            acc     <= ment;
            acc_vld <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // checks on the sequencer
  `FFRA_ASSERT_NOW(a_count_bound, 1'b1, count <= MAX_C, "block count above table depth")
  `FFRA_ASSERT_NEXT(a_accept_busy, accept, (state != S_IDLE) || out_valid, "item accepted but neither busy nor answered")
  `FFRA_ASSERT_NOW(a_merge_order, (state == S_MERGE) && chk_vld, wr_ptr <= chk_idx, "merge write passed the read walk")

endmodule

// ===== rtl/core/ffra_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ffra_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/testbench.sv =====
// testbench for the first-fit region allocator core: directed and random alloc/free items
// depends on ffra_pkg and first_fit_region_allocator_core
module testbench;
  import ffra_pkg::*;

  localparam int NBLK = DEF_MAX_BLOCKS;
  localparam int HDR  = DEF_HEADER_BYTES;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  ffra_in_t in_item;
  ffra_out_t out_item;
  logic [15:0] cfg_data;

  first_fit_region_allocator_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow of the block table
  logic [15:0] sh_off [NBLK];
  logic [15:0] sh_size[NBLK];
  logic        sh_free[NBLK];
  int unsigned sh_count;
  logic [16:0] sh_bump;
  logic [15:0] sh_region;

  ffra_out_t expected_results[$];
  int errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void merge_free_runs();
    int unsigned wr;
    wr = 0;
    for (int unsigned rd = 0; rd < sh_count; rd++) begin
      if (sh_free[rd] && wr > 0 && sh_free[wr-1]) begin
        sh_size[wr-1] = sh_size[wr-1] + sh_size[rd] + 16'(HDR);
      end else begin
        sh_off[wr] = sh_off[rd];
        sh_size[wr] = sh_size[rd];
        sh_free[wr] = sh_free[rd];
        wr++;
      end
    end
    sh_count = wr;
  endfunction

  function automatic ffra_out_t predict_allocation(ffra_in_t it);
    ffra_out_t r;
    logic [31:0] remain;
    r.granted_offset = '0;
    r.status = STAT_OK;
    if (it.func == FUNC_FREE) begin
      r.status = STAT_UNKNOWN;
      for (int unsigned i = 0; i < sh_count; i++) begin
        if (32'(sh_off[i]) + HDR == 32'(it.payload_offset)) begin
          sh_free[i] = 1'b1;
          merge_free_runs();
          r.status = STAT_OK;
          break;
        end
      end
      return r;
    end
    if (32'(sh_bump) + 32'(it.request_bytes) + HDR < 32'(sh_region)) begin
      if (sh_count >= NBLK) begin
        r.status = STAT_FULL;
        return r;
      end
      sh_off[sh_count] = sh_bump[15:0];
      sh_size[sh_count] = it.request_bytes;
      sh_free[sh_count] = 1'b0;
      sh_count++;
      r.granted_offset = sh_bump[15:0] + 16'(HDR);
      sh_bump = sh_bump + 17'(it.request_bytes) + 17'(HDR);
      return r;
    end
    for (int unsigned i = 0; i < sh_count; i++) begin
      if (sh_free[i] && sh_size[i] >= it.request_bytes) begin
        remain = 32'(sh_size[i]) - 32'(it.request_bytes);
        if (remain >= HDR) begin
          if (sh_count >= NBLK) begin
            r.status = STAT_FULL;
            return r;
          end
          for (int unsigned j = sh_count; j > i + 1; j--) begin
            sh_off[j] = sh_off[j-1];
            sh_size[j] = sh_size[j-1];
            sh_free[j] = sh_free[j-1];
          end
          sh_off[i+1] = sh_off[i] + 16'(HDR) + it.request_bytes;
          sh_size[i+1] = 16'(remain - HDR);
          sh_free[i+1] = 1'b1;
          sh_count++;
        end
        sh_size[i] = it.request_bytes;
        sh_free[i] = 1'b0;
        r.granted_offset = sh_off[i] + 16'(HDR);
        return r;
      end
    end
    r.status = STAT_NOSPACE;
    return r;
  endfunction

  // result checker with random receiver stall
  int stall_left = 0;
  always @(posedge clk) begin
    ffra_out_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected item %h", $time, out_item);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.granted_offset !== exp_r.granted_offset) begin
            $display("%0t granted_offset expected %0d actual %0d", $time,
                     exp_r.granted_offset, out_item.granted_offset);
            errors++;
          end
          if (out_item.status !== exp_r.status) begin
            $display("%0t status expected %0d actual %0d", $time,
                     exp_r.status, out_item.status);
            errors++;
          end
        end
        stall_left = $urandom_range(0, 10);
      end
      // bursts without stalls now and then
      if (stall_left > 0 && $urandom_range(0, 7) != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
      end
    end
  end

  // valid stays high into the next item when there is no gap
  task automatic send_item(logic fn, logic [15:0] req, logic [15:0] poff);
    ffra_in_t it;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func = fn;
    it.request_bytes = req;
    it.payload_offset = poff;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_allocation(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_region(logic [15:0] val);
    drain();
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_region = val;
  endtask

  // offset of a live or stale block, or garbage
  function automatic logic [15:0] pick_offset();
    if (sh_count > 0 && $urandom_range(0, 9) != 0)
      return sh_off[$urandom_range(0, sh_count - 1)] + 16'(HDR);
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    set_region(16'd200);
    send_item(FUNC_ALLOC, 16'd0, 16'hffff);     // zero-byte append
    send_item(FUNC_ALLOC, 16'd100, 16'd0);      // append
    send_item(FUNC_ALLOC, 16'hffff, 16'd0);     // no space
    send_item(FUNC_FREE, 16'd0, 16'd48);        // free second block
    send_item(FUNC_FREE, 16'hffff, 16'd48);     // already free
    send_item(FUNC_FREE, 16'd0, 16'hffff);      // unknown
    send_item(FUNC_FREE, 16'd0, 16'd0);         // unknown
    send_item(FUNC_ALLOC, 16'd10, 16'd0);       // append
    send_item(FUNC_ALLOC, 16'd60, 16'd0);       // split
    send_item(FUNC_FREE, 16'd0, 16'd24);
    send_item(FUNC_FREE, 16'd0, 16'd58);
    send_item(FUNC_FREE, 16'd0, 16'd92);        // unknown
    set_region(16'd0);
    send_item(FUNC_ALLOC, 16'd0, 16'd0);
    set_region(16'hffff);
    for (int i = 0; i < 8; i++) send_item(FUNC_ALLOC, 16'd8000, 16'd0);
    send_item(FUNC_ALLOC, 16'hffff, 16'd0);
  endtask

  task automatic test_table_full();
    set_region(16'hffff);
    for (int i = 0; i < 60; i++) send_item(FUNC_ALLOC, 16'($urandom_range(0, 3)), 16'd0);
    send_item(FUNC_ALLOC, 16'd1, 16'd0);        // one-byte alloc with the bump offset near the region end
    send_item(FUNC_FREE, 16'd0, sh_off[3] + 16'(HDR));
    send_item(FUNC_FREE, 16'd0, sh_off[0] + 16'(HDR));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3)
        send_item(1'($urandom), 16'($urandom), 16'($urandom));
      else if ($urandom_range(0, 1) == 0)
        send_item(FUNC_ALLOC, ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 300)), 16'($urandom));
      else
        send_item(FUNC_FREE, 16'($urandom), pick_offset());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sh_count = 0;
    sh_bump = '0;
    sh_region = 16'hffff;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(300);
    set_region(16'd3000);
    test_random(200);
    set_region(16'd600);
    test_random(200);
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
